/* rtl/tte_pkg.sv */
package tte_pkg;

    localparam int BLOCK_SIZE = 512;
    localparam int HDR_BYTES  = 4;

    localparam logic [3:0]  MAX_RETRIES_RST = 4'd5;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [2:0] {
        CMD_START_READ  = 3'd0,
        CMD_START_WRITE = 3'd1,
        CMD_PKT_RX      = 3'd2,
        CMD_RX_TIMEOUT  = 3'd3,
        CMD_RX_FAIL     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_DATA = 2'd1,
        SEND_ACK  = 2'd2,
        SEND_ERR  = 2'd3
    } t_send_kind;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_BAD_SIZE  = 3'd1,
        RSN_BAD_OP    = 3'd2,
        RSN_BAD_ACK   = 3'd3,
        RSN_BAD_BLOCK = 3'd4
    } t_reason;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_FAIL    = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_KILLED  = 3'd4,
        ST_PEER    = 3'd5,
        ST_IGNORED = 3'd6
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic [9:0]  packet_length;
        logic [9:0]  next_chunk_length;
    } t_event;

    typedef struct packed {
        t_send_kind  send_kind;
        logic [15:0] send_block;
        logic [9:0]  send_length;
        t_reason     error_reason;
        logic [9:0]  store_length;
        t_status     transfer_status;
    } t_result;

endpackage

/* rtl/tte_in_reg.sv */
module tte_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tte_pkg::t_event i_evt,
    input  logic            i_take,
    output logic            o_valid,
    output tte_pkg::t_event o_evt
);

    logic            r_valid;
    tte_pkg::t_event r_evt;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_evt <= i_evt;
        end
    end

endmodule

/* rtl/tte_seq.sv */
module tte_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_wdata,
    input  logic             i_fire,
    input  tte_pkg::t_event  i_evt,
    output tte_pkg::t_result o_res
);

    logic [3:0]     r_max_retries;
    tte_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_block, n_block;
    logic [3:0]     r_tcount, n_tcount;
    logic [9:0]     r_chunk, n_chunk;

    logic [9:0]  nlen;
    logic [9:0]  payload;
    logic [3:0]  lim;
    logic [3:0]  tinc;
    logic [15:0] blk_inc;
    logic        bad_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= tte_pkg::MAX_RETRIES_RST;
        end else if (i_cfg_we) begin
            r_max_retries <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tte_pkg::MODE_IDLE;
            r_block  <= '0;
            r_tcount <= '0;
            r_chunk  <= '0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_block  <= n_block;
            r_tcount <= n_tcount;
            r_chunk  <= n_chunk;
        end
    end

    assign nlen     = (32'(i_evt.next_chunk_length) > tte_pkg::BLOCK_SIZE)
                      ? 10'(tte_pkg::BLOCK_SIZE) : i_evt.next_chunk_length;
    assign payload  = i_evt.packet_length - 10'(tte_pkg::HDR_BYTES);
    assign lim      = (r_max_retries == 4'd0) ? 4'd1 : r_max_retries;
    assign tinc     = r_tcount + 4'd1;
    assign blk_inc  = r_block + 16'd1;
    assign bad_size = (32'(i_evt.packet_length) < tte_pkg::HDR_BYTES) ||
                      (32'(i_evt.packet_length) > tte_pkg::BLOCK_SIZE + tte_pkg::HDR_BYTES);

    always_comb begin
        n_mode   = r_mode;
        n_block  = r_block;
        n_tcount = r_tcount;
        n_chunk  = r_chunk;
        o_res    = '{send_kind: tte_pkg::SEND_NONE, send_block: '0, send_length: '0,
                     error_reason: tte_pkg::RSN_NONE, store_length: '0,
                     transfer_status: tte_pkg::ST_IGNORED};

        unique case (i_evt.command)
            tte_pkg::CMD_START_READ: begin
                n_mode   = tte_pkg::MODE_READ;
                n_block  = 16'd1;
                n_tcount = '0;
                n_chunk  = nlen;
                o_res.send_kind       = tte_pkg::SEND_DATA;
                o_res.send_block      = 16'd1;
                o_res.send_length     = nlen;
                o_res.transfer_status = tte_pkg::ST_RUN;
            end
            tte_pkg::CMD_START_WRITE: begin
                n_mode   = tte_pkg::MODE_WRITE;
                n_block  = '0;
                n_tcount = '0;
                n_chunk  = '0;
                o_res.send_kind       = tte_pkg::SEND_ACK;
                o_res.transfer_status = tte_pkg::ST_RUN;
            end
            tte_pkg::CMD_RX_FAIL: begin
                if (r_mode != tte_pkg::MODE_IDLE) begin
                    n_mode   = tte_pkg::MODE_IDLE;
                    n_tcount = '0;
                    o_res.transfer_status = tte_pkg::ST_KILLED;
                end
            end
            tte_pkg::CMD_RX_TIMEOUT: begin
                if (r_mode != tte_pkg::MODE_IDLE) begin
                    n_tcount = tinc;
                    if (tinc >= lim) begin
                        n_mode   = tte_pkg::MODE_IDLE;
                        n_tcount = '0;
                        o_res.transfer_status = tte_pkg::ST_TIMEOUT;
                    end else if (r_mode == tte_pkg::MODE_READ) begin
                        o_res.send_kind       = tte_pkg::SEND_DATA;
                        o_res.send_block      = r_block;
                        o_res.send_length     = r_chunk;
                        o_res.transfer_status = tte_pkg::ST_RUN;
                    end else begin
                        o_res.send_kind       = tte_pkg::SEND_ACK;
                        o_res.send_block      = r_block;
                        o_res.transfer_status = tte_pkg::ST_RUN;
                    end
                end
            end
            tte_pkg::CMD_PKT_RX: begin
                if (r_mode != tte_pkg::MODE_IDLE) begin
                    n_mode   = tte_pkg::MODE_IDLE;
                    n_tcount = '0;
                    o_res.transfer_status = tte_pkg::ST_FAIL;
                    priority if (bad_size) begin
                        o_res.send_kind    = tte_pkg::SEND_ERR;
                        o_res.error_reason = tte_pkg::RSN_BAD_SIZE;
                    end else if (i_evt.packet_opcode == tte_pkg::OP_ERROR) begin
                        o_res.transfer_status = tte_pkg::ST_PEER;
                    end else if (r_mode == tte_pkg::MODE_READ) begin
                        priority if (i_evt.packet_opcode != tte_pkg::OP_ACK) begin
                            o_res.send_kind    = tte_pkg::SEND_ERR;
                            o_res.error_reason = tte_pkg::RSN_BAD_OP;
                        end else if (i_evt.packet_block != r_block) begin
                            o_res.send_kind    = tte_pkg::SEND_ERR;
                            o_res.error_reason = tte_pkg::RSN_BAD_ACK;
                        end else if (32'(r_chunk) < tte_pkg::BLOCK_SIZE) begin
                            o_res.transfer_status = tte_pkg::ST_DONE;
                        end else begin
                            n_mode   = tte_pkg::MODE_READ;
                            n_block  = blk_inc;
                            n_chunk  = nlen;
                            o_res.send_kind       = tte_pkg::SEND_DATA;
                            o_res.send_block      = blk_inc;
                            o_res.send_length     = nlen;
                            o_res.transfer_status = tte_pkg::ST_RUN;
                        end
                    end else begin
                        priority if (i_evt.packet_opcode != tte_pkg::OP_DATA) begin
                            o_res.send_kind    = tte_pkg::SEND_ERR;
                            o_res.error_reason = tte_pkg::RSN_BAD_OP;
                        end else if (i_evt.packet_block != blk_inc) begin
                            o_res.send_kind    = tte_pkg::SEND_ERR;
                            o_res.error_reason = tte_pkg::RSN_BAD_BLOCK;
                        end else begin
                            n_block = blk_inc;
                            o_res.send_kind    = tte_pkg::SEND_ACK;
                            o_res.send_block   = blk_inc;
                            o_res.store_length = payload;
                            if (32'(payload) < tte_pkg::BLOCK_SIZE) begin
                                o_res.transfer_status = tte_pkg::ST_DONE;
                            end else begin
                                n_mode = tte_pkg::MODE_WRITE;
                                o_res.transfer_status = tte_pkg::ST_RUN;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.transfer_status != tte_pkg::ST_RUN &&
        o_res.transfer_status != tte_pkg::ST_IGNORED |=> r_mode == tte_pkg::MODE_IDLE)
        else $error("ending status did not return to idle");

    a_data_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.send_kind == tte_pkg::SEND_DATA |=> r_mode == tte_pkg::MODE_READ)
        else $error("DATA sent outside read mode");

    a_sent_block_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_res.send_kind == tte_pkg::SEND_DATA ||
                   o_res.send_kind == tte_pkg::SEND_ACK)
        |=> r_block == $past(o_res.send_block))
        else $error("block count differs from block sent");

    a_ignored_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.transfer_status == tte_pkg::ST_IGNORED
        |=> $stable(r_mode) && $stable(r_block) && $stable(r_tcount))
        else $error("ignored event changed state");

endmodule

/* rtl/tte_out_reg.sv */
module tte_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tte_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_take,
    output logic             o_valid,
    output tte_pkg::t_result o_res
);

    logic             r_valid;
    tte_pkg::t_result r_res;

    assign o_take  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_take) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/tftp_transfer_engine.sv */
// A result passes through the input register, then the result register, once its input
// transfer is accepted; a held result register keeps the item waiting in the input register.
// Throughput: one item per cycle; the input register and result register
// both move whenever the result register is empty or being taken.
// Reset (i_rst_n low, synchronous): no item held, mode idle, block and
// timeout counts and chunk length zero, max_retries back to 5.
module tftp_transfer_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [3:0]                        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode[15:0], block[31:16], length[41:32], next_chunk_length[51:42]
    input  logic [tte_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command[2:0]
    input  logic [2:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // send_block[15:0], send_length[25:16], error_reason[28:26],
    // store_length[38:29], transfer_status[41:39]
    output logic [tte_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // send_kind[1:0]
    output logic [1:0]                        m_axis_tuser
);

    tte_pkg::t_event  s_evt;
    tte_pkg::t_event  q_evt;
    tte_pkg::t_result seq_res;
    tte_pkg::t_result out_res;
    logic             q_valid;
    logic             take;
    logic             fire;

    assign s_evt.command           = tte_pkg::t_cmd'(s_axis_tuser);
    assign s_evt.packet_opcode     = s_axis_tdata[15:0];
    assign s_evt.packet_block      = s_axis_tdata[31:16];
    assign s_evt.packet_length     = s_axis_tdata[41:32];
    assign s_evt.next_chunk_length = s_axis_tdata[51:42];

    assign fire = q_valid && take;

    tte_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_evt   (s_evt),
        .i_take  (take),
        .o_valid (q_valid),
        .o_evt   (q_evt)
    );

    tte_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_evt       (q_evt),
        .o_res       (seq_res)
    );

    tte_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (q_valid),
        .i_res   (seq_res),
        .i_ready (m_axis_tready),
        .o_take  (take),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.send_kind;
    assign m_axis_tdata = {6'd0, out_res.transfer_status, out_res.store_length,
                           out_res.error_reason, out_res.send_length, out_res.send_block};

endmodule

/* sim/tftp_transfer_engine_checker.sv */
`timescale 1ns / 100ps

module tftp_transfer_engine_checker
    import tte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // opcode[15:0], block[31:16], length[41:32], next_chunk_length[51:42]
    input  logic [55:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // send_block[15:0], send_length[25:16], error_reason[28:26],
    // store_length[38:29], transfer_status[41:39]
    input  logic [47:0] m_axis_tdata,
    // send_kind[1:0]
    input  logic [1:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    t_result     expected_results[$];
    logic [3:0]  retry_limit;
    t_mode       xfer_mode;
    logic [15:0] block_cnt;
    logic [3:0]  timeout_cnt;
    logic [9:0]  chunk_len;
    int          mismatches = 0;

    function automatic t_result result_of(t_send_kind kind, logic [15:0] blk,
                                          logic [9:0] slen, t_reason rsn,
                                          logic [9:0] store, t_status st);
        t_result r;
        r.send_kind       = kind;
        r.send_block      = blk;
        r.send_length     = slen;
        r.error_reason    = rsn;
        r.store_length    = store;
        r.transfer_status = st;
        return r;
    endfunction

    function automatic t_result end_transfer(t_send_kind kind, t_reason rsn, t_status st);
        xfer_mode   = MODE_IDLE;
        timeout_cnt = 4'd0;
        return result_of(kind, 16'd0, 10'd0, rsn, 10'd0, st);
    endfunction

    function automatic t_result next_result(t_event ev);
        t_result     r;
        logic [9:0]  nlen;
        logic [3:0]  lim;
        logic [9:0]  payload;
        nlen = (ev.next_chunk_length > BLOCK_SIZE) ? 10'(BLOCK_SIZE) : ev.next_chunk_length;
        r = result_of(SEND_NONE, 16'd0, 10'd0, RSN_NONE, 10'd0, ST_IGNORED);
        if (ev.command == CMD_START_READ) begin
            xfer_mode   = MODE_READ;
            block_cnt   = 16'd1;
            timeout_cnt = 4'd0;
            chunk_len   = nlen;
            r = result_of(SEND_DATA, block_cnt, chunk_len, RSN_NONE, 10'd0, ST_RUN);
        end else if (ev.command == CMD_START_WRITE) begin
            xfer_mode   = MODE_WRITE;
            block_cnt   = 16'd0;
            timeout_cnt = 4'd0;
            chunk_len   = 10'd0;
            r = result_of(SEND_ACK, 16'd0, 10'd0, RSN_NONE, 10'd0, ST_RUN);
        end else if (xfer_mode == MODE_IDLE || ev.command > CMD_RX_FAIL) begin
            r = result_of(SEND_NONE, 16'd0, 10'd0, RSN_NONE, 10'd0, ST_IGNORED);
        end else if (ev.command == CMD_RX_FAIL) begin
            r = end_transfer(SEND_NONE, RSN_NONE, ST_KILLED);
        end else if (ev.command == CMD_RX_TIMEOUT) begin
            lim = (retry_limit == 4'd0) ? 4'd1 : retry_limit;
            timeout_cnt = timeout_cnt + 4'd1;
            if (timeout_cnt >= lim) begin
                r = end_transfer(SEND_NONE, RSN_NONE, ST_TIMEOUT);
            end else if (xfer_mode == MODE_READ) begin
                r = result_of(SEND_DATA, block_cnt, chunk_len, RSN_NONE, 10'd0, ST_RUN);
            end else begin
                r = result_of(SEND_ACK, block_cnt, 10'd0, RSN_NONE, 10'd0, ST_RUN);
            end
        end else if (ev.packet_length < HDR_BYTES ||
                     ev.packet_length > BLOCK_SIZE + HDR_BYTES) begin
            r = end_transfer(SEND_ERR, RSN_BAD_SIZE, ST_FAIL);
        end else if (ev.packet_opcode == OP_ERROR) begin
            r = end_transfer(SEND_NONE, RSN_NONE, ST_PEER);
        end else if (xfer_mode == MODE_READ) begin
            if (ev.packet_opcode != OP_ACK) begin
                r = end_transfer(SEND_ERR, RSN_BAD_OP, ST_FAIL);
            end else if (ev.packet_block != block_cnt) begin
                r = end_transfer(SEND_ERR, RSN_BAD_ACK, ST_FAIL);
            end else if (chunk_len < BLOCK_SIZE) begin
                r = end_transfer(SEND_NONE, RSN_NONE, ST_DONE);
            end else begin
                block_cnt   = block_cnt + 16'd1;
                timeout_cnt = 4'd0;
                chunk_len   = nlen;
                r = result_of(SEND_DATA, block_cnt, chunk_len, RSN_NONE, 10'd0, ST_RUN);
            end
        end else begin
            if (ev.packet_opcode != OP_DATA) begin
                r = end_transfer(SEND_ERR, RSN_BAD_OP, ST_FAIL);
            end else if (ev.packet_block != block_cnt + 16'd1) begin
                r = end_transfer(SEND_ERR, RSN_BAD_BLOCK, ST_FAIL);
            end else begin
                payload     = ev.packet_length - 10'(HDR_BYTES);
                block_cnt   = block_cnt + 16'd1;
                timeout_cnt = 4'd0;
                if (payload < BLOCK_SIZE) begin
                    xfer_mode = MODE_IDLE;
                end
                r = result_of(SEND_ACK, block_cnt, 10'd0, RSN_NONE, payload,
                              (payload < BLOCK_SIZE) ? ST_DONE : ST_RUN);
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_event  ev;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            retry_limit = MAX_RETRIES_RST;
            xfer_mode   = MODE_IDLE;
            block_cnt   = 16'd0;
            timeout_cnt = 4'd0;
            chunk_len   = 10'd0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                retry_limit = i_cfg_wdata;
            end
            // results first: a result never belongs to an event taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.send_kind       = t_send_kind'(m_axis_tuser);
                got.send_block      = m_axis_tdata[15:0];
                got.send_length     = m_axis_tdata[25:16];
                got.error_reason    = t_reason'(m_axis_tdata[28:26]);
                got.store_length    = m_axis_tdata[38:29];
                got.transfer_status = t_status'(m_axis_tdata[41:39]);
                if (expected_results.size() == 0) begin
                    $error("result transfer with no event outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("send_kind", want.send_kind, got.send_kind);
                    check_field("send_block", want.send_block, got.send_block);
                    check_field("send_length", want.send_length, got.send_length);
                    check_field("error_reason", want.error_reason, got.error_reason);
                    check_field("store_length", want.store_length, got.store_length);
                    check_field("transfer_status", want.transfer_status,
                                got.transfer_status);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ev.command           = t_cmd'(s_axis_tuser);
                ev.packet_opcode     = s_axis_tdata[15:0];
                ev.packet_block      = s_axis_tdata[31:16];
                ev.packet_length     = s_axis_tdata[41:32];
                ev.next_chunk_length = s_axis_tdata[51:42];
                expected_results.push_back(next_result(ev));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

/* sim/tftp_transfer_engine_test.sv */
`timescale 1ns / 100ps

module tftp_transfer_engine_test;
    import tte_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 330;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [3:0]  i_cfg_wdata   = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          fail_count;
    int          pending;
    int          burst_left  = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          rx_hold     = 0;
    bit          gaps_on     = 1'b1;
    bit          rx_stall_on = 1'b1;
    logic [3:0]  retry_cfg   = MAX_RETRIES_RST;

    tftp_transfer_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tftp_transfer_engine_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= !rx_stall_on || ($urandom_range(0, 3) != 0);
            rx_hold       <= $urandom_range(0, 11);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tftp_transfer_engine_test NOT OK");
            $finish;
        end
    end

    function automatic t_event make_event(t_cmd cmd, logic [15:0] opc, logic [15:0] blk,
                                          logic [9:0] len, logic [9:0] nlen);
        t_event ev;
        ev.command           = cmd;
        ev.packet_opcode     = opc;
        ev.packet_block      = blk;
        ev.packet_length     = len;
        ev.next_chunk_length = nlen;
        return ev;
    endfunction

    function automatic t_event rand_event(t_cmd cmd);
        return make_event(cmd, 16'($urandom), 16'($urandom),
                          10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    endfunction

    // mostly full chunks so read transfers run several blocks
    function automatic logic [9:0] rand_chunk();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return 10'(BLOCK_SIZE);
        end else if (pick < 9) begin
            return 10'($urandom_range(0, BLOCK_SIZE - 1));
        end
        return 10'($urandom_range(BLOCK_SIZE + 1, 1023));
    endfunction

    task automatic send_item(t_event ev);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= {4'd0, ev.next_chunk_length, ev.packet_length,
                          ev.packet_block, ev.packet_opcode};
        s_axis_tuser  <= ev.command;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_retries(logic [3:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        retry_cfg = value;
    endtask

    task automatic send_broken(logic [15:0] good_op, logic [15:0] good_blk);
        t_event ev;
        ev = make_event(CMD_PKT_RX, good_op, good_blk, 10'($urandom_range(4, 516)),
                        rand_chunk());
        case ($urandom_range(0, 6))
            0: ev.packet_length = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 3))
                                                              : 10'($urandom_range(517, 1023));
            1: ev.packet_opcode = OP_ERROR;
            2: ev.packet_opcode = 16'($urandom);
            3: ev.packet_block = good_blk + 16'($urandom_range(1, 65535));
            4: ev.command = CMD_RX_FAIL;
            5: ev.command = ($urandom_range(0, 1) == 0) ? CMD_START_READ : CMD_START_WRITE;
            default: ev.command = t_cmd'($urandom_range(5, 7));
        endcase
        send_item(ev);
    endtask

    task automatic read_session();
        t_event      ev;
        logic [15:0] blk;
        logic [9:0]  nlen;
        bit          full;
        bit          active;
        int          lim;
        int          nt;
        lim = (retry_cfg == 4'd0) ? 1 : retry_cfg;
        blk = 16'd1;
        nlen = rand_chunk();
        full = (nlen >= BLOCK_SIZE);
        ev = rand_event(CMD_START_READ);
        ev.next_chunk_length = nlen;
        send_item(ev);
        active = 1'b1;
        while (active) begin
            nt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, lim) : 0;
            repeat (nt) send_item(rand_event(CMD_RX_TIMEOUT));
            if (nt >= lim) begin
                active = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                send_broken(OP_ACK, blk);
                active = 1'b0;
            end else begin
                nlen = rand_chunk();
                send_item(make_event(CMD_PKT_RX, OP_ACK, blk, 10'($urandom_range(4, 516)),
                                     nlen));
                if (!full) begin
                    active = 1'b0;
                end
                blk  = blk + 16'd1;
                full = (nlen >= BLOCK_SIZE);
            end
        end
    endtask

    task automatic write_session();
        logic [15:0] blk;
        logic [9:0]  len;
        bit          active;
        int          lim;
        int          nt;
        lim = (retry_cfg == 4'd0) ? 1 : retry_cfg;
        blk = 16'd0;
        send_item(rand_event(CMD_START_WRITE));
        active = 1'b1;
        while (active) begin
            nt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, lim) : 0;
            repeat (nt) send_item(rand_event(CMD_RX_TIMEOUT));
            if (nt >= lim) begin
                active = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                send_broken(OP_DATA, blk + 16'd1);
                active = 1'b0;
            end else begin
                len = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(4, 515)) : 10'd516;
                send_item(make_event(CMD_PKT_RX, OP_DATA, blk + 16'd1, len,
                                     10'($urandom_range(0, 1023))));
                blk = blk + 16'd1;
                if (len < BLOCK_SIZE + HDR_BYTES) begin
                    active = 1'b0;
                end
            end
        end
    endtask

    task automatic run_random(int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                read_session();
            end else if (pick < 8) begin
                write_session();
            end else begin
                repeat ($urandom_range(1, 4)) send_item(rand_event(t_cmd'($urandom_range(0, 7))));
            end
        end
    endtask

    task automatic run_directed();
        // events with no transfer open, and an unknown command
        send_item(rand_event(CMD_RX_TIMEOUT));
        send_item(rand_event(CMD_PKT_RX));
        send_item(rand_event(CMD_RX_FAIL));
        send_item(rand_event(t_cmd'(3'd7)));
        // read: oversized chunk, resend, zero-length chunk, done
        send_item(make_event(CMD_START_READ, 16'd0, 16'd0, 10'd0, 10'd1023));
        send_item(make_event(CMD_RX_TIMEOUT, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023));
        send_item(make_event(CMD_PKT_RX, OP_ACK, 16'd1, 10'd4, 10'd0));
        send_item(make_event(CMD_PKT_RX, OP_ACK, 16'd2, 10'd516, 10'd512));
        // restart over a running read, then write with resend and oversized packet
        send_item(make_event(CMD_START_READ, 16'd0, 16'd0, 10'd0, 10'd512));
        send_item(make_event(CMD_START_WRITE, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023));
        send_item(make_event(CMD_PKT_RX, OP_DATA, 16'd1, 10'd516, 10'd0));
        send_item(make_event(CMD_RX_TIMEOUT, 16'd0, 16'd0, 10'd0, 10'd0));
        send_item(make_event(CMD_PKT_RX, OP_DATA, 16'd2, 10'd517, 10'd0));
        send_item(make_event(CMD_START_WRITE, 16'd0, 16'd0, 10'd0, 10'd0));
        send_item(make_event(CMD_PKT_RX, OP_DATA, 16'd1, 10'd4, 10'd0));
        send_item(make_event(CMD_START_WRITE, 16'd0, 16'd0, 10'd0, 10'd0));
        send_item(make_event(CMD_PKT_RX, OP_DATA, 16'd1, 10'd3, 10'd0));
        send_item(make_event(CMD_START_WRITE, 16'd0, 16'd0, 10'd0, 10'd0));
        send_item(make_event(CMD_PKT_RX, OP_ACK, 16'd1, 10'd4, 10'd0));
        // duplicate ack in read mode
        send_item(make_event(CMD_START_READ, 16'd0, 16'd0, 10'd0, 10'd512));
        send_item(make_event(CMD_PKT_RX, OP_ACK, 16'd0, 10'd4, 10'd512));
        send_item(make_event(CMD_START_READ, 16'd0, 16'd0, 10'd0, 10'd512));
        send_item(make_event(CMD_PKT_RX, OP_ERROR, 16'd1, 10'd20, 10'd0));
        send_item(make_event(CMD_START_WRITE, 16'd0, 16'd0, 10'd0, 10'd0));
        send_item(make_event(CMD_PKT_RX, OP_DATA, 16'd7, 10'd516, 10'd0));
        send_item(make_event(CMD_START_READ, 16'd0, 16'd0, 10'd0, 10'd100));
        send_item(make_event(CMD_RX_FAIL, 16'd0, 16'd0, 10'd0, 10'd0));
    endtask

    initial begin
        int i;
        logic [3:0] retry_plan [6];
        retry_plan = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)), 4'd5,
                       4'($urandom_range(1, 15))};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (i = 0; i < 6; i++) begin
            wait_idle();
            write_retries(retry_plan[i]);
            gaps_on     = (i != 2);
            rx_stall_on = (i != 3);
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tftp_transfer_engine_test OK");
        end else begin
            $display("tftp_transfer_engine_test NOT OK");
        end
        $finish;
    end

endmodule

/* tftp_transfer_engine.f */
rtl/tte_pkg.sv
rtl/tte_in_reg.sv
rtl/tte_seq.sv
rtl/tte_out_reg.sv
rtl/tftp_transfer_engine.sv
sim/tftp_transfer_engine_checker.sv
sim/tftp_transfer_engine_test.sv
